// ----- sv/rsa_pkg.sv -----
// Shared types and constants of the randomness statistics accumulator.
`default_nettype none

package rsa_pkg;

   // Item operations
   typedef enum logic {
      OP_DATA = 1'b0,
      OP_READ = 1'b1
   } op_type;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 48;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FOLD_ENABLE    = 2'd0,
      CSR_BIT_MODE       = 2'd1,
      CSR_INCIRCLE_LIMIT = 2'd2
   } csr_index_type;

   // Field widths
   localparam int CORR_W  = 63;
   localparam int COUNT_W = 48;
   localparam int LIMIT_W = 48;
   localparam int HIST_W  = 32;
   localparam int SYMBOLS = 256;

   localparam logic [LIMIT_W-1:0] INCIRCLE_RESET = 48'd281474943156225;

   // Queue depths
   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 4;

   // Classified item handed from front to back
   typedef struct packed {
      op_type     op;
      logic [7:0] value;      // data byte, folded when enabled, or symbol of a read
      logic       bit_mode;
      logic       in_range;   // read bank exists
   } cmd_type;

   // One result item
   typedef struct packed {
      logic [CORR_W-1:0]  correlation_sum;
      logic [COUNT_W-1:0] total_count;
      logic [COUNT_W-1:0] trial_count;
      logic [COUNT_W-1:0] inside_count;
      logic [7:0]         first_value;
      logic               first_valid;
      logic [7:0]         last_value;
      logic [COUNT_W-1:0] ones_count;
      logic [COUNT_W-1:0] zeros_count;
      logic [HIST_W-1:0]  hist_count;
   } rsp_type;

   // Histogram access request
   typedef struct packed {
      logic valid;   // read the entry this cycle
      logic incr;    // and bump it in the next cycle
   } hist_req_type;

endpackage

`default_nettype wire

// ----- sv/rsa_fifo.sv -----
// Small first-in first-out queue of fixed-width items.
`default_nettype none

module rsa_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- sv/rsa_front.sv -----
// Front end: case folding, bank selection and classification of each item.
`default_nettype none

module rsa_front import rsa_pkg::*; #(
   parameter int HIST_BANKS = 4,
   parameter int BANK_W = (HIST_BANKS > 1) ? $clog2(HIST_BANKS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              fold_enable,
   input  logic              bit_mode,
   input  logic              accept,
   input  logic              req_op,
   input  logic [7:0]        req_data_byte,
   input  logic              req_buffer_start,
   input  logic [1:0]        req_read_bank,
   input  logic [7:0]        req_read_symbol,
   output cmd_type           cmd,
   output logic [BANK_W-1:0] cmd_bank
);

   localparam logic [7:0] ASCII_BASE  = 8'h41;
   localparam logic [7:0] ASCII_SPAN  = 8'd26;
   localparam logic [7:0] LATIN_BASE  = 8'hC0;
   localparam logic [7:0] LATIN_SPAN  = 8'd31;
   localparam logic [7:0] LATIN_SKIP  = 8'hD7;
   localparam logic [7:0] FOLD_OFFSET = 8'h20;
   localparam int         RB_W        = (BANK_W > 2) ? BANK_W : 2;

   // Map upper case ASCII and Latin-1 letters to lower case
   function automatic logic [7:0] fold_byte(input logic [7:0] c);
      logic ascii_up;
      logic latin_up;
      ascii_up = (8'(c - ASCII_BASE) < ASCII_SPAN);
      latin_up = (8'(c - LATIN_BASE) < LATIN_SPAN) && (c != LATIN_SKIP);
      return (ascii_up || latin_up) ? 8'(c + FOLD_OFFSET) : c;
   endfunction

   logic [BANK_W-1:0] bank_pos_ff, bank_pos_in;
   logic [BANK_W-1:0] bank_now;
   logic [RB_W-1:0]   read_bank_ext;
   logic              is_data;

   assign is_data       = (op_type'(req_op) == OP_DATA);
   assign bank_now      = req_buffer_start ? '0 : bank_pos_ff;
   assign read_bank_ext = RB_W'(req_read_bank);

   // Classify the item
   always_comb begin
      cmd.op       = op_type'(req_op);
      cmd.bit_mode = bit_mode;
      cmd.in_range = (int'(req_read_bank) < HIST_BANKS);
      if (is_data) begin
         cmd.value = fold_enable ? fold_byte(req_data_byte) : req_data_byte;
         cmd_bank  = bank_now;
      end else begin
         cmd.value = req_read_symbol;
         cmd_bank  = read_bank_ext[BANK_W-1:0];
      end
   end

   // Advance the bank position on byte-mode data items only; a buffer start resets it
   always_comb begin
      bank_pos_in = bank_pos_ff;
      if (accept && is_data) begin
         if (bit_mode) begin
            bank_pos_in = bank_now;
         end else begin
            bank_pos_in = (bank_now == BANK_W'(HIST_BANKS - 1)) ? '0 : bank_now + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_pos_ff <= '0;
      end else begin
         bank_pos_ff <= bank_pos_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/rsa_hist.sv -----
// Banked symbol histogram: clearing sweep and read-modify-write with bypass.
`default_nettype none

module rsa_hist import rsa_pkg::*; #(
   parameter int HIST_BANKS = 4,
   parameter int ADDR_W = $clog2(HIST_BANKS * SYMBOLS)
) (
   input  logic              clock,
   input  logic              reset,
   input  hist_req_type      req,
   input  logic [ADDR_W-1:0] addr,
   output logic [HIST_W-1:0] value,
   output logic              clearing
);

   localparam int DEPTH = HIST_BANKS * SYMBOLS;

   logic [HIST_W-1:0] mem [DEPTH];

   logic              clearing_ff, clearing_in;
   logic [ADDR_W-1:0] clear_addr_ff;
   logic              s1_incr_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [HIST_W-1:0] rdata_ff;
   logic              wr_valid_ff;
   logic [ADDR_W-1:0] wr_addr_ff;
   logic [HIST_W-1:0] wr_data_ff;
   logic [HIST_W-1:0] bumped;

   assign clearing    = clearing_ff;
   assign clearing_in = clearing_ff && (clear_addr_ff != ADDR_W'(DEPTH - 1));

   // Take the entry written last cycle when the read raced that write
   assign value  = (wr_valid_ff && (wr_addr_ff == s1_addr_ff)) ? wr_data_ff : rdata_ff;
   assign bumped = (&value) ? value : value + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
         s1_incr_ff    <= 1'b0;
         wr_valid_ff   <= 1'b0;
      end else begin
         clearing_ff   <= clearing_in;
         clear_addr_ff <= clear_addr_ff + 1'b1;
         s1_incr_ff    <= req.incr;
         wr_valid_ff   <= s1_incr_ff;
      end
   end

   // Hold the access address and the last write for the bypass
   always_ff @(posedge clock) begin
      if (req.valid) begin
         s1_addr_ff <= addr;
      end
      if (s1_incr_ff) begin
         wr_addr_ff <= s1_addr_ff;
         wr_data_ff <= bumped;
      end
   end

   // Memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clear_addr_ff] <= '0;
      end else if (s1_incr_ff) begin
         mem[s1_addr_ff] <= bumped;
      end
      if (req.valid) begin
         rdata_ff <= mem[addr];
      end
   end

endmodule

`default_nettype wire

// ----- sv/rsa_back.sv -----
// Back end: statistics accumulators, Monte Carlo pipeline and histogram update.
`default_nettype none

module rsa_back import rsa_pkg::*; #(
   parameter int HIST_BANKS = 4,
   parameter int BANK_W = (HIST_BANKS > 1) ? $clog2(HIST_BANKS) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [LIMIT_W-1:0] incircle_limit,
   input  logic               cmd_valid,
   input  cmd_type            cmd,
   input  logic [BANK_W-1:0]  cmd_bank,
   output logic               cmd_pop,
   input  logic               rsp_taken,
   output logic               rsp_push,
   output rsp_type            rsp_data,
   output logic               clearing
);

   localparam int ADDR_W = $clog2(HIST_BANKS * SYMBOLS);
   localparam int CRED_W = $clog2(RSP_DEPTH + 1);
   localparam logic [2:0] GROUP_LAST = 3'd5;

   function automatic logic [3:0] pop8(input logic [7:0] v);
      logic [3:0] n;
      n = '0;
      for (int i = 0; i < 8; i++) begin
         n = n + 4'(v[i]);
      end
      return n;
   endfunction

   function automatic logic [COUNT_W-1:0] sat_add48(input logic [COUNT_W-1:0] a,
                                                    input logic [COUNT_W-1:0] b);
      logic [COUNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COUNT_W] ? '1 : s[COUNT_W-1:0];
   endfunction

   function automatic logic [CORR_W-1:0] sat_add63(input logic [CORR_W-1:0] a,
                                                   input logic [CORR_W-1:0] b);
      logic [CORR_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CORR_W] ? '1 : s[CORR_W-1:0];
   endfunction

   // Accumulator state
   logic [CORR_W-1:0]  corr_ff, corr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] ones_ff, ones_in;
   logic [COUNT_W-1:0] zeros_ff, zeros_in;
   logic [COUNT_W-1:0] trials_ff, trials_in;
   logic [COUNT_W-1:0] inside_ff, inside_in;
   logic [7:0]         carry_ff, carry_in;
   logic               carry_valid_ff, carry_valid_in;
   logic [7:0]         first_ff, first_in;
   logic               first_valid_ff, first_valid_in;
   logic [7:0]         last_ff, last_in;
   logic [2:0]         fill_ff, fill_in;
   logic [7:0]         group_bytes_ff [5];
   logic [CRED_W-1:0]  credit_ff, credit_in;

   // Pipeline registers
   logic               s1_valid_ff, s2_valid_ff;
   logic               s1_eval_ff, s2_eval_ff;
   logic               s1_read_ff, s1_in_range_ff;
   logic [23:0]        s1_x_ff, s1_y_ff;
   logic [47:0]        s2_xx_ff, s2_yy_ff;
   rsp_type            s1_rsp_ff, s1_rsp_in;
   rsp_type            s2_rsp_ff, s2_rsp_in;

   logic               issue;
   logic               is_data;
   logic               group_done;
   logic [7:0]         b;
   logic [15:0]        prod;
   logic [3:0]         ones;
   logic [3:0]         pairs;
   logic [BANK_W+7:0]  full_addr;
   logic [48:0]        norm_sq;
   logic               hit;
   hist_req_type       hist_req;
   logic [HIST_W-1:0]  hist_value;

   assign issue      = cmd_valid && (credit_ff != '0) && !clearing;
   assign cmd_pop    = issue;
   assign is_data    = issue && (cmd.op == OP_DATA);
   assign b          = cmd.value;
   assign prod       = carry_ff * b;
   assign ones       = pop8(b);
   assign pairs      = pop8(b & (b >> 1)) +
                       4'(carry_valid_ff && carry_ff[0] && b[7]);
   assign group_done = (fill_ff == GROUP_LAST);
   assign full_addr  = {cmd_bank, b};

   assign hist_req.valid = issue;
   assign hist_req.incr  = is_data && !cmd.bit_mode;

   rsa_hist #(
      .HIST_BANKS (HIST_BANKS),
      .ADDR_W     (ADDR_W)
   ) u_hist (
      .clock    (clock),
      .reset    (reset),
      .req      (hist_req),
      .addr     (full_addr[ADDR_W-1:0]),
      .value    (hist_value),
      .clearing (clearing)
   );

   // Issue stage: update the byte and bit statistics
   always_comb begin
      corr_in        = corr_ff;
      count_in       = count_ff;
      ones_in        = ones_ff;
      zeros_in       = zeros_ff;
      carry_in       = carry_ff;
      carry_valid_in = carry_valid_ff;
      first_in       = first_ff;
      first_valid_in = first_valid_ff;
      last_in        = last_ff;
      fill_in        = fill_ff;
      if (is_data) begin
         if (!cmd.bit_mode) begin
            if (carry_valid_ff) begin
               corr_in = sat_add63(corr_ff, CORR_W'(prod));
            end else begin
               first_in       = b;
               first_valid_in = 1'b1;
            end
            carry_in = b;
            last_in  = b;
            count_in = sat_add48(count_ff, COUNT_W'(1));
         end else begin
            ones_in  = sat_add48(ones_ff, COUNT_W'(ones));
            zeros_in = sat_add48(zeros_ff, COUNT_W'(4'd8 - ones));
            corr_in  = sat_add63(corr_ff, CORR_W'(pairs));
            if (!carry_valid_ff) begin
               first_in       = {7'd0, b[7]};
               first_valid_in = 1'b1;
            end
            carry_in = {7'd0, b[0]};
            last_in  = {7'd0, b[0]};
            count_in = sat_add48(count_ff, COUNT_W'(8));
         end
         carry_valid_in = 1'b1;
         fill_in        = group_done ? '0 : fill_ff + 1'b1;
      end
   end

   // Snapshot of the statistics after this item
   always_comb begin
      s1_rsp_in                 = '0;
      s1_rsp_in.correlation_sum = corr_in;
      s1_rsp_in.total_count     = count_in;
      s1_rsp_in.first_value     = first_in;
      s1_rsp_in.first_valid     = first_valid_in;
      s1_rsp_in.last_value      = last_in;
      s1_rsp_in.ones_count      = ones_in;
      s1_rsp_in.zeros_count     = zeros_in;
   end

   // Spend a credit per issue; return credits as results leave the output queue
   always_comb begin
      case ({issue, rsp_taken})
         2'b10:   credit_in = credit_ff - 1'b1;
         2'b01:   credit_in = credit_ff + 1'b1;
         default: credit_in = credit_ff;
      endcase
   end

   // Histogram stage: attach the read entry
   always_comb begin
      s2_rsp_in            = s1_rsp_ff;
      s2_rsp_in.hist_count = (s1_read_ff && s1_in_range_ff) ? hist_value : '0;
   end

   // Monte Carlo stage: in-circle test and trial counts
   assign norm_sq = {1'b0, s2_xx_ff} + {1'b0, s2_yy_ff};
   assign hit     = (norm_sq <= {1'b0, incircle_limit});

   always_comb begin
      trials_in = trials_ff;
      inside_in = inside_ff;
      if (s2_valid_ff && s2_eval_ff) begin
         trials_in = sat_add48(trials_ff, COUNT_W'(1));
         if (hit) begin
            inside_in = sat_add48(inside_ff, COUNT_W'(1));
         end
      end
   end

   always_comb begin
      rsp_data              = s2_rsp_ff;
      rsp_data.trial_count  = trials_in;
      rsp_data.inside_count = inside_in;
   end

   assign rsp_push = s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         corr_ff        <= '0;
         count_ff       <= '0;
         ones_ff        <= '0;
         zeros_ff       <= '0;
         trials_ff      <= '0;
         inside_ff      <= '0;
         carry_ff       <= '0;
         carry_valid_ff <= 1'b0;
         first_ff       <= '0;
         first_valid_ff <= 1'b0;
         last_ff        <= '0;
         fill_ff        <= '0;
         credit_ff      <= CRED_W'(RSP_DEPTH);
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s1_eval_ff     <= 1'b0;
         s2_eval_ff     <= 1'b0;
      end else begin
         corr_ff        <= corr_in;
         count_ff       <= count_in;
         ones_ff        <= ones_in;
         zeros_ff       <= zeros_in;
         trials_ff      <= trials_in;
         inside_ff      <= inside_in;
         carry_ff       <= carry_in;
         carry_valid_ff <= carry_valid_in;
         first_ff       <= first_in;
         first_valid_ff <= first_valid_in;
         last_ff        <= last_in;
         fill_ff        <= fill_in;
         credit_ff      <= credit_in;
         s1_valid_ff    <= issue;
         s2_valid_ff    <= s1_valid_ff;
         s1_eval_ff     <= is_data && group_done;
         s2_eval_ff     <= s1_eval_ff;
      end
   end

   // Payload stages
   always_ff @(posedge clock) begin
      if (is_data && !group_done) begin
         group_bytes_ff[fill_ff] <= b;
      end
      s1_rsp_ff      <= s1_rsp_in;
      s1_read_ff     <= (cmd.op == OP_READ);
      s1_in_range_ff <= cmd.in_range;
      s1_x_ff        <= {group_bytes_ff[0], group_bytes_ff[1], group_bytes_ff[2]};
      s1_y_ff        <= {group_bytes_ff[3], group_bytes_ff[4], b};
      s2_rsp_ff      <= s2_rsp_in;
      s2_xx_ff       <= s1_x_ff * s1_x_ff;
      s2_yy_ff       <= s1_y_ff * s1_y_ff;
   end

endmodule

`default_nettype wire

// ----- sv/randomness_stats_accumulator.sv -----
// Top level of the randomness statistics accumulator.
//
// Channel  Direction  Handshake               Payload
// req      in         req_push / req_full     op, data_byte, buffer_start, read_bank, read_symbol
// rsp      out        rsp_empty / rsp_pop     statistics snapshot and histogram entry
// csr      in         csr_wr_en               csr_index, csr_wdata
//
// One item per cycle sustained while req_full is low; a result reaches the rsp
// ports through command queue, issue, histogram read and Monte Carlo stage.
// The rate is set by the histogram read-modify-write, which uses one read and
// one write port of the memory per cycle with a one-entry bypass.
// After reset the histogram is swept to zero, every entry of every bank, while
// req_full stays high; configuration writes are taken as usual.
// A stalled rsp side fills a four-entry result queue, then the two-entry
// command queue, then raises req_full.
`default_nettype none

module randomness_stats_accumulator import rsa_pkg::*; #(
   parameter int HIST_BANKS = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   // item input
   input  logic                   req_push,
   output logic                   req_full,
   input  logic                   req_op,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_buffer_start,
   input  logic [1:0]             req_read_bank,
   input  logic [7:0]             req_read_symbol,
   // result output
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [CORR_W-1:0]      rsp_correlation_sum,
   output logic [COUNT_W-1:0]     rsp_total_count,
   output logic [COUNT_W-1:0]     rsp_trial_count,
   output logic [COUNT_W-1:0]     rsp_inside_count,
   output logic [7:0]             rsp_first_value,
   output logic                   rsp_first_valid,
   output logic [7:0]             rsp_last_value,
   output logic [COUNT_W-1:0]     rsp_ones_count,
   output logic [COUNT_W-1:0]     rsp_zeros_count,
   output logic [HIST_W-1:0]      rsp_hist_count,
   // configuration
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int BANK_W = (HIST_BANKS > 1) ? $clog2(HIST_BANKS) : 1;
   localparam int CMD_W  = $bits(cmd_type) + BANK_W;
   localparam int RSP_W  = $bits(rsp_type);

   logic               fold_enable_ff;
   logic               bit_mode_ff;
   logic [LIMIT_W-1:0] incircle_limit_ff;

   logic               accept;
   logic               clearing;
   cmd_type            front_cmd;
   logic [BANK_W-1:0]  front_bank;
   logic [CMD_W-1:0]   cmd_q_data;
   cmd_type            back_cmd;
   logic [BANK_W-1:0]  back_bank;
   logic               cmd_full;
   logic               cmd_empty;
   logic               cmd_pop;
   logic               rsp_push;
   rsp_type            rsp_in;
   logic [RSP_W-1:0]   rsp_q_data;
   rsp_type            rsp_q;
   logic               rsp_full;
   logic               rsp_taken;

   assign req_full  = cmd_full || clearing;
   assign accept    = req_push && !req_full;
   assign rsp_taken = rsp_pop && !rsp_empty;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fold_enable_ff    <= 1'b0;
         bit_mode_ff       <= 1'b0;
         incircle_limit_ff <= INCIRCLE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FOLD_ENABLE:    fold_enable_ff    <= csr_wdata[0];
            CSR_BIT_MODE:       bit_mode_ff       <= csr_wdata[0];
            CSR_INCIRCLE_LIMIT: incircle_limit_ff <= csr_wdata[LIMIT_W-1:0];
            default:            ;
         endcase
      end
   end

   rsa_front #(
      .HIST_BANKS (HIST_BANKS),
      .BANK_W     (BANK_W)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .fold_enable      (fold_enable_ff),
      .bit_mode         (bit_mode_ff),
      .accept           (accept),
      .req_op           (req_op),
      .req_data_byte    (req_data_byte),
      .req_buffer_start (req_buffer_start),
      .req_read_bank    (req_read_bank),
      .req_read_symbol  (req_read_symbol),
      .cmd              (front_cmd),
      .cmd_bank         (front_bank)
   );

   rsa_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data ({front_cmd, front_bank}),
      .pop       (cmd_pop),
      .pop_data  (cmd_q_data),
      .full      (cmd_full),
      .empty     (cmd_empty)
   );

   assign {back_cmd, back_bank} = cmd_q_data;

   rsa_back #(
      .HIST_BANKS (HIST_BANKS),
      .BANK_W     (BANK_W)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .incircle_limit (incircle_limit_ff),
      .cmd_valid      (!cmd_empty),
      .cmd            (back_cmd),
      .cmd_bank       (back_bank),
      .cmd_pop        (cmd_pop),
      .rsp_taken      (rsp_taken),
      .rsp_push       (rsp_push),
      .rsp_data       (rsp_in),
      .clearing       (clearing)
   );

   rsa_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in),
      .pop       (rsp_pop),
      .pop_data  (rsp_q_data),
      .full      (rsp_full),
      .empty     (rsp_empty)
   );

   // Drive the result ports from the head of the queue
   assign rsp_q               = rsp_q_data;
   assign rsp_correlation_sum = rsp_q.correlation_sum;
   assign rsp_total_count     = rsp_q.total_count;
   assign rsp_trial_count     = rsp_q.trial_count;
   assign rsp_inside_count    = rsp_q.inside_count;
   assign rsp_first_value     = rsp_q.first_value;
   assign rsp_first_valid     = rsp_q.first_valid;
   assign rsp_last_value      = rsp_q.last_value;
   assign rsp_ones_count      = rsp_q.ones_count;
   assign rsp_zeros_count     = rsp_q.zeros_count;
   assign rsp_hist_count      = rsp_q.hist_count;

   // Credits keep the result queue from overflowing
   a_rsp_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result pushed into a full result queue");

   // The back pipeline never stalls once an item is issued
   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> ##2 rsp_push)
      else $error("issued item did not reach the result queue in two cycles");

   // Nothing moves while the histogram sweep runs
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      clearing |-> (cmd_empty && rsp_empty && !rsp_push))
      else $error("item in flight during histogram clearing");

endmodule

`default_nettype wire

// ----- bench/randomness_stats_accumulator_tb.sv -----
// Self-checking testbench for the randomness statistics accumulator.

module randomness_stats_accumulator_tb;
   import rsa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int BANKS        = 4;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 5000;
   localparam int REPORT_LINES = 50;

   localparam logic [63:0] CORR_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] COUNT_MAX = 64'h0000_FFFF_FFFF_FFFF;
   localparam logic [HIST_W-1:0]  HIST_MAX  = '1;
   localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;

   // Upper-case ranges that fold to lower case
   localparam logic [7:0] ASCII_UPPER_FIRST = 8'h41;
   localparam logic [7:0] ASCII_UPPER_LAST  = 8'h5A;
   localparam logic [7:0] LATIN_UPPER_FIRST = 8'hC0;
   localparam logic [7:0] LATIN_UPPER_LAST  = 8'hDE;
   localparam logic [7:0] LATIN_TIMES_SIGN  = 8'hD7;
   localparam logic [7:0] CASE_OFFSET       = 8'h20;

   typedef enum {POP_STEADY, POP_HALF, POP_SPARSE, POP_MOSTLY} pop_mode_type;

   logic                   clock;
   logic                   reset;
   logic                   req_push;
   logic                   req_full;
   logic                   req_op;
   logic [7:0]             req_data_byte;
   logic                   req_buffer_start;
   logic [1:0]             req_read_bank;
   logic [7:0]             req_read_symbol;
   logic                   rsp_empty;
   logic                   rsp_pop;
   logic [CORR_W-1:0]      rsp_correlation_sum;
   logic [COUNT_W-1:0]     rsp_total_count;
   logic [COUNT_W-1:0]     rsp_trial_count;
   logic [COUNT_W-1:0]     rsp_inside_count;
   logic [7:0]             rsp_first_value;
   logic                   rsp_first_valid;
   logic [7:0]             rsp_last_value;
   logic [COUNT_W-1:0]     rsp_ones_count;
   logic [COUNT_W-1:0]     rsp_zeros_count;
   logic [HIST_W-1:0]      rsp_hist_count;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // Mirror of the block's registers and statistics
   logic                fold_cfg;
   logic                bit_cfg;
   logic [LIMIT_W-1:0]  limit_cfg;
   logic [HIST_W-1:0]   hist_model [BANKS][SYMBOLS];
   int unsigned         bank_pos;
   logic [63:0]         corr_acc;
   logic [7:0]          carry_val;
   logic                carry_ok;
   logic [7:0]          first_val;
   logic                first_ok;
   logic [7:0]          last_val;
   logic [7:0]          group_bytes [6];
   int unsigned         group_fill;
   logic [63:0]         trials_acc, inside_acc, count_acc, ones_acc, zeros_acc;

   rsp_type pending_snapshots [$];

   int  error_count;
   int  items_sent;
   int  results_checked;
   int  setting_count;
   int  burst_left;
   bit  hold_request;

   randomness_stats_accumulator #(
      .HIST_BANKS(BANKS)
   ) i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_op              (req_op),
      .req_data_byte       (req_data_byte),
      .req_buffer_start    (req_buffer_start),
      .req_read_bank       (req_read_bank),
      .req_read_symbol     (req_read_symbol),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_correlation_sum (rsp_correlation_sum),
      .rsp_total_count     (rsp_total_count),
      .rsp_trial_count     (rsp_trial_count),
      .rsp_inside_count    (rsp_inside_count),
      .rsp_first_value     (rsp_first_value),
      .rsp_first_valid     (rsp_first_valid),
      .rsp_last_value      (rsp_last_value),
      .rsp_ones_count      (rsp_ones_count),
      .rsp_zeros_count     (rsp_zeros_count),
      .rsp_hist_count      (rsp_hist_count),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [63:0] sat_add(logic [63:0] acc, logic [63:0] inc,
                                           logic [63:0] ceiling);
      if (acc >= ceiling || inc > ceiling - acc)
         return ceiling;
      return acc + inc;
   endfunction

   function automatic logic [7:0] fold_case(logic [7:0] c);
      if ((c >= ASCII_UPPER_FIRST && c <= ASCII_UPPER_LAST) ||
          (c >= LATIN_UPPER_FIRST && c <= LATIN_UPPER_LAST && c != LATIN_TIMES_SIGN))
         return c + CASE_OFFSET;
      return c;
   endfunction

   // Apply one accepted item to the mirror and return the snapshot it yields
   function automatic rsp_type advance_stats(op_type op, logic [7:0] raw, logic start,
                                             logic [1:0] bank, logic [7:0] sym);
      rsp_type     snap;
      logic [7:0]  b;
      logic [63:0] prod;
      logic [63:0] pairs;
      int unsigned ones;
      logic [23:0] px, py;
      logic [63:0] norm_sq;
      snap = '0;
      if (op == OP_READ) begin
         if (bank < BANKS)
            snap.hist_count = hist_model[bank][sym];
      end else begin
         b = fold_cfg ? fold_case(raw) : raw;
         if (start)
            bank_pos = 0;
         if (!bit_cfg) begin
            if (carry_ok) begin
               prod = 64'(carry_val) * 64'(b);
               corr_acc = sat_add(corr_acc, prod, CORR_MAX);
            end else begin
               first_val = b;
               first_ok = 1'b1;
            end
            carry_val = b;
            last_val = b;
            if (hist_model[bank_pos][b] != HIST_MAX)
               hist_model[bank_pos][b] = hist_model[bank_pos][b] + 1;
            bank_pos = (bank_pos + 1) % BANKS;
            count_acc = sat_add(count_acc, 64'd1, COUNT_MAX);
         end else begin
            ones = $countones(b);
            pairs = 64'($countones(b & (b >> 1)));
            ones_acc = sat_add(ones_acc, 64'(ones), COUNT_MAX);
            zeros_acc = sat_add(zeros_acc, 64'(8 - ones), COUNT_MAX);
            if (carry_ok) begin
               pairs = pairs + 64'(carry_val[0] & b[7]);
            end else begin
               first_val = {7'd0, b[7]};
               first_ok = 1'b1;
            end
            corr_acc = sat_add(corr_acc, pairs, CORR_MAX);
            carry_val = {7'd0, b[0]};
            last_val = {7'd0, b[0]};
            count_acc = sat_add(count_acc, 64'd8, COUNT_MAX);
         end
         carry_ok = 1'b1;

         // Monte Carlo: six bytes make one point
         if (group_fill > 5)
            group_fill = 0;
         group_bytes[group_fill] = b;
         group_fill++;
         if (group_fill == 6) begin
            px = {group_bytes[0], group_bytes[1], group_bytes[2]};
            py = {group_bytes[3], group_bytes[4], group_bytes[5]};
            norm_sq = 64'(px) * 64'(px) + 64'(py) * 64'(py);
            trials_acc = sat_add(trials_acc, 64'd1, COUNT_MAX);
            if (norm_sq <= 64'(limit_cfg))
               inside_acc = sat_add(inside_acc, 64'd1, COUNT_MAX);
            group_fill = 0;
         end
      end
      snap.correlation_sum = corr_acc[CORR_W-1:0];
      snap.total_count     = count_acc[COUNT_W-1:0];
      snap.trial_count     = trials_acc[COUNT_W-1:0];
      snap.inside_count    = inside_acc[COUNT_W-1:0];
      snap.first_value     = first_val;
      snap.first_valid     = first_ok;
      snap.last_value      = last_val;
      snap.ones_count      = ones_acc[COUNT_W-1:0];
      snap.zeros_count     = zeros_acc[COUNT_W-1:0];
      return snap;
   endfunction

   // ------------------------------------------------------------------ checking

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      // keep the log short when the block is badly broken
      if (error_count < REPORT_LINES)
         $display("[%0t] mismatch %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
         report_mismatch(name, got, want);
   endtask

   // Compare each popped item against the oldest snapshot
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_snapshots.size() == 0) begin
            report_mismatch("result with nothing pending", 64'(rsp_hist_count), 64'd0);
         end else begin
            want = pending_snapshots.pop_front();
            check_field("correlation_sum", 64'(rsp_correlation_sum),
                        64'(want.correlation_sum));
            check_field("total_count", 64'(rsp_total_count), 64'(want.total_count));
            check_field("trial_count", 64'(rsp_trial_count), 64'(want.trial_count));
            check_field("inside_count", 64'(rsp_inside_count), 64'(want.inside_count));
            check_field("first_value", 64'(rsp_first_value), 64'(want.first_value));
            check_field("first_valid", 64'(rsp_first_valid), 64'(want.first_valid));
            check_field("last_value", 64'(rsp_last_value), 64'(want.last_value));
            check_field("ones_count", 64'(rsp_ones_count), 64'(want.ones_count));
            check_field("zeros_count", 64'(rsp_zeros_count), 64'(want.zeros_count));
            check_field("hist_count", 64'(rsp_hist_count), 64'(want.hist_count));
         end
         results_checked++;
      end
   end

   // ------------------------------------------------------------------ stimulus

   // Offer one item and hold it until the block takes it
   task automatic send_item(op_type op, logic [7:0] data, logic start,
                            logic [1:0] bank, logic [7:0] sym);
      req_push         <= 1'b1;
      req_op           <= op;
      req_data_byte    <= data;
      req_buffer_start <= start;
      req_read_bank    <= bank;
      req_read_symbol  <= sym;
      @(posedge clock);
      while (req_full !== 1'b0)
         @(posedge clock);
      pending_snapshots.push_back(advance_stats(op, data, start, bank, sym));
      items_sent++;
   endtask

   task automatic send_byte(logic [7:0] data, logic start);
      send_item(OP_DATA, data, start, 2'd0, 8'd0);
   endtask

   task automatic send_read(logic [1:0] bank, logic [7:0] sym);
      send_item(OP_READ, 8'd0, 1'b0, bank, sym);
   endtask

   // Drop the push line for a random gap at the end of each burst
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 8);
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
   endtask

   // Drain every pending result, then let the pipeline settle
   task automatic wait_idle();
      req_push <= 1'b0;
      while (pending_snapshots.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_FOLD_ENABLE:    fold_cfg = value[0];
         CSR_BIT_MODE:       bit_cfg = value[0];
         CSR_INCIRCLE_LIMIT: limit_cfg = value[LIMIT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Write all three registers; unused upper bits carry random noise
   task automatic apply_setting(logic fold, logic mode, logic [LIMIT_W-1:0] limit);
      logic [CSR_DATA_W-1:0] noise;
      noise = CSR_DATA_W'({$urandom, $urandom});
      write_csr(CSR_FOLD_ENABLE, {noise[CSR_DATA_W-1:1], fold});
      noise = CSR_DATA_W'({$urandom, $urandom});
      write_csr(CSR_BIT_MODE, {noise[CSR_DATA_W-1:1], mode});
      write_csr(CSR_INCIRCLE_LIMIT, limit);
      setting_count++;
   endtask

   task automatic send_random_item();
      logic [7:0] data;
      logic [7:0] sym;
      int         pick;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         // half the reads aim at the small alphabet so counts are nonzero
         sym = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 15))
                                           : 8'($urandom_range(0, 255));
         send_item(OP_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   2'($urandom_range(0, 3)), sym);
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 25)
            data = 8'($urandom_range(8'h3F, 8'h5C));
         else if (pick < 45)
            data = 8'($urandom_range(8'hBE, 8'hE0));
         else if (pick < 65)
            data = 8'($urandom_range(0, 15));
         else
            data = 8'($urandom_range(0, 255));
         send_item(OP_DATA, data, $urandom_range(0, 19) == 0,
                   2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
   endtask

   // --------------------------------------------------------------------- tests

   // First byte ever arrives in bit mode; then switch to bytes with a carried bit
   task automatic test_bit_statistics();
      apply_setting(1'b0, 1'b1, INCIRCLE_RESET);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b1);   // buffer start in bit mode, carry pairs with msb
      send_byte(8'hAA, 1'b0);
      send_byte(8'h01, 1'b0);
      wait_idle();
      apply_setting(1'b0, 1'b0, INCIRCLE_RESET);
      send_byte(8'h7F, 1'b0);   // multiplied by the carried bit
   endtask

   task automatic test_incircle_limits();
      wait_idle();
      apply_setting(1'b0, 1'b0, '0);
      // align to a fresh group
      while (group_fill != 0)
         send_byte(8'($urandom_range(0, 255)), 1'b0);
      repeat (6) send_byte(8'h00, 1'b0);   // distance zero sits on a zero limit
      wait_idle();
      apply_setting(1'b0, 1'b0, LIMIT_MAX);
      repeat (6) send_byte(8'hFF, 1'b0);   // far corner lies outside any limit
   endtask

   task automatic test_case_folding();
      wait_idle();
      apply_setting(1'b1, 1'b0, INCIRCLE_RESET);
      send_byte(8'h41, 1'b0);
      send_byte(8'h5B, 1'b0);
      send_byte(8'hC0, 1'b0);
      send_byte(8'hD7, 1'b0);
      send_byte(8'hDE, 1'b0);
      send_byte(8'hDF, 1'b0);
   endtask

   task automatic test_histogram_reads();
      send_byte(8'h61, 1'b1);
      send_read(2'd0, 8'h61);
      send_read(2'd0, 8'h00);
      send_read(2'd3, 8'hFF);
      send_read(2'd1, 8'hE0);
      send_read(2'd2, 8'h80);
   endtask

   task automatic test_random_phases();
      logic [LIMIT_W-1:0] limit;
      logic [23:0]        radius;
      int                 count;
      for (int phase = 0; phase < 8; phase++) begin
         wait_idle();
         case ($urandom_range(0, 2))
            0: limit = LIMIT_W'({$urandom, $urandom});
            1: begin
               radius = 24'($urandom);
               limit = LIMIT_W'(radius) * LIMIT_W'(radius);
            end
            default: limit = INCIRCLE_RESET;
         endcase
         case (phase)
            0: apply_setting(1'b0, 1'b0, INCIRCLE_RESET);
            1: apply_setting(1'b1, 1'b0, '0);
            2: apply_setting(1'b0, 1'b1, LIMIT_MAX);
            3: apply_setting(1'b1, 1'b1, limit);
            default: apply_setting(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0,
                                   limit);
         endcase
         count = $urandom_range(190, 250);
         repeat (count) begin
            pace_sender();
            send_random_item();
         end
      end
   endtask

   // Stall the output long enough that the input side fills and pushes back
   task automatic test_result_backpressure();
      wait_idle();
      hold_request = 1'b1;
      repeat (80) send_random_item();
   endtask

   // ------------------------------------------------------------ result stalls

   initial begin : rsp_stall_pattern
      int           hold_left;
      int           mode_left;
      pop_mode_type mode;
      hold_left = 0;
      mode_left = 0;
      mode = POP_STEADY;
      rsp_pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode = pop_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 120);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            case (mode)
               POP_STEADY: rsp_pop <= 1'b1;
               POP_HALF:   rsp_pop <= ($urandom_range(0, 1) == 0);
               POP_SPARSE: rsp_pop <= ($urandom_range(0, 4) == 0);
               default:    rsp_pop <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   // ------------------------------------------------------------------ watchdog

   initial begin : watchdog
      int stuck;
      stuck = 0;
      while (stuck < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
            stuck = 0;
         else
            stuck++;
      end
      $display("no item moved for %0d cycles", STALL_LIMIT);
      $display("simulation failed");
      $finish;
   end

   // ---------------------------------------------------------------- main flow

   initial begin : main_flow
      reset            <= 1'b1;
      req_push         <= 1'b0;
      req_op           <= OP_DATA;
      req_data_byte    <= '0;
      req_buffer_start <= 1'b0;
      req_read_bank    <= '0;
      req_read_symbol  <= '0;
      csr_wr_en        <= 1'b0;
      csr_index        <= CSR_FOLD_ENABLE;
      csr_wdata        <= '0;

      // Mirror starts from the reset state
      fold_cfg = 1'b0;
      bit_cfg = 1'b0;
      limit_cfg = INCIRCLE_RESET;
      for (int k = 0; k < BANKS; k++)
         for (int s = 0; s < SYMBOLS; s++)
            hist_model[k][s] = '0;
      bank_pos = 0;
      corr_acc = '0;
      carry_val = '0;
      carry_ok = 1'b0;
      first_val = '0;
      first_ok = 1'b0;
      last_val = '0;
      group_fill = 0;
      trials_acc = '0;
      inside_acc = '0;
      count_acc = '0;
      ones_acc = '0;
      zeros_acc = '0;
      error_count = 0;
      items_sent = 0;
      results_checked = 0;
      setting_count = 0;
      burst_left = 0;
      hold_request = 1'b0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_bit_statistics();
      test_incircle_limits();
      test_case_folding();
      test_histogram_reads();
      test_random_phases();
      test_result_backpressure();
      wait_idle();

      $display("checked %0d results from %0d items over %0d register settings",
               results_checked, items_sent, setting_count);
      $display("covered byte and bit statistics, case folding, histogram reads, %0s",
               "in-circle limits and a long output stall");
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
